// ===== rtl/ppsm_pkg.sv =====
// shared types and constants of the pulse period speed meter
package ppsm_pkg;

    // register indexes of the configuration port
    localparam logic [7:0] CFG_AVERAGE_WINDOW  = 8'd0;
    localparam logic [7:0] CFG_PULSES_PER_MILE = 8'd1;
    localparam logic [7:0] CFG_TIMER_CLOCK_HZ  = 8'd2;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;

    // field widths
    localparam int WINDOW_W = 5;
    localparam int PPM_W    = 20;
    localparam int CLK_W    = 29;
    localparam int STAMP_W  = 32;
    localparam int SPEED_W  = 24;

    // reset values of the configuration registers
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 5'd5;
    localparam logic [PPM_W-1:0]    PPM_RESET    = 20'd8000;
    localparam logic [CLK_W-1:0]    CLK_RESET    = 29'd64000000;

    // behaviour constants
    localparam logic [STAMP_W-1:0] MIN_PERIOD_TICKS = 32'd100;
    localparam logic [STAMP_W-1:0] PULSE_TIMEOUT_MS = 32'd2000;
    localparam logic [PPM_W-1:0]   HOUR_Q8_SCALE    = 20'd921600;  // 3600 s times 256
    localparam logic [SPEED_W-1:0] SPEED_MAX        = 24'hFFFFFF;

    // divider and multiplier sizes
    localparam int MUL_A_W   = 32;
    localparam int DIV_W     = MUL_A_W + PPM_W;   // full product width
    localparam int NUM_W     = CLK_W + PPM_W;     // clock times hour scale
    localparam int DIV_CNT_W = 6;

    // request to the shared divider
    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] iters;
    } t_div_req;

endpackage

// ===== rtl/ppsm_if.sv =====
// handshake channels of the speed meter: capture/read items, results, configuration
interface ppsm_in_if import ppsm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               action;
    logic [STAMP_W-1:0] capture_ticks;
    logic [STAMP_W-1:0] now_ms;

    modport source (output valid, output action, output capture_ticks, output now_ms,
                    input ready);
    modport sink   (input valid, input action, input capture_ticks, input now_ms,
                    output ready);
endinterface

interface ppsm_out_if import ppsm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [SPEED_W-1:0] speed_mph_q8;
    logic               stopped;

    modport source (output valid, output speed_mph_q8, output stopped, input ready);
    modport sink   (input valid, input speed_mph_q8, input stopped, output ready);
endinterface

interface ppsm_cfg_if import ppsm_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/pulse_period_speed_meter_core.sv =====
// top level of the pulse period speed meter: period ring, averaging and speed sequencer
//
// Capture items (action 0) write the wrapping period to the previous stamp into a ring
// ram of RING_DEPTH entries when it is at least 100 ticks. Read items (action 1) report
// speed = clock * 3600 / (average period * pulses per mile) in Q16.8, saturated. A read
// that ends early (no data, no pulse for over 2000 ms, or zero pulses per mile) goes
// straight to the output register. A full read walks the N newest ring entries through
// the single ram read port, runs the averaging division, forms the numerator and then
// the denominator on the shared multiplier, runs the speed division on the shared
// bit-per-cycle divider and then loads the output register. One item is in progress at
// a time; the result sits in an output register, so the next item is taken while it
// waits. Configuration writes are always taken.
module pulse_period_speed_meter_core import ppsm_pkg::*; #(
    parameter int RING_DEPTH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ppsm_in_if.sink        i_in,
    ppsm_out_if.source     o_out,
    ppsm_cfg_if.sink       i_cfg
);

    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int SW = STAMP_W + CW;

    localparam logic [AW-1:0] LAST_SLOT = AW'(RING_DEPTH - 1);
    localparam logic [CW-1:0] FULL_FILL = CW'(RING_DEPTH);

    // sequencer states
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SUM     = 3'd1;
    localparam logic [2:0] S_AVG     = 3'd2;
    localparam logic [2:0] S_MUL_NUM = 3'd3;
    localparam logic [2:0] S_MUL_DEN = 3'd4;
    localparam logic [2:0] S_SPD     = 3'd5;
    localparam logic [2:0] S_OUT     = 3'd6;

    // configuration registers
    logic [WINDOW_W-1:0] r_avg_win;
    logic [PPM_W-1:0]    r_ppm;
    logic [CLK_W-1:0]    r_clk_hz;

    // capture state
    logic [STAMP_W-1:0] r_prev_stamp;
    logic               r_seen;
    logic [AW-1:0]      r_wslot;
    logic [CW-1:0]      r_fill;
    logic [STAMP_W-1:0] r_last_pulse;

    // sequencer state
    logic [2:0]         r_state, n_state;
    logic [AW-1:0]      r_rslot, n_rslot;
    logic [CW-1:0]      r_left, n_left;
    logic [CW-1:0]      r_n, n_n;
    logic               r_pend, n_pend;
    logic [SW-1:0]      r_sum, n_sum;
    logic [STAMP_W-1:0] r_avg, n_avg;
    logic [NUM_W-1:0]   r_num, n_num;
    logic [DIV_W-1:0]   r_den, n_den;
    logic [SPEED_W-1:0] r_res_speed, n_res_speed;
    logic               r_res_stopped, n_res_stopped;

    // output register
    logic               r_out_valid, n_out_valid;
    logic [SPEED_W-1:0] r_out_speed, n_out_speed;
    logic               r_out_stopped, n_out_stopped;

    logic               in_xfer;
    logic               cap_xfer;
    logic               rd_xfer;
    logic [STAMP_W-1:0] period;
    logic               keep_period;
    logic [7:0]         win_ext;
    logic [7:0]         fill_ext;
    logic [7:0]         n_min;
    logic [CW-1:0]      n_items;
    logic [STAMP_W-1:0] idle_ms;
    logic               timed_out;

    logic [STAMP_W-1:0] ram_rdata;

    logic [MUL_A_W-1:0] mul_a;
    logic [PPM_W-1:0]   mul_b;
    logic [DIV_W-1:0]   mul_p;

    t_div_req           div_req;
    logic [DIV_W-1:0]   div_dividend;
    logic [DIV_W-1:0]   div_divisor;
    logic               div_done;
    logic [DIV_W-1:0]   div_quo;

    assign in_xfer  = i_in.valid && i_in.ready;
    assign cap_xfer = in_xfer && !i_in.action;
    assign rd_xfer  = in_xfer && i_in.action;

    // configuration writes, unknown indexes ignored
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg_win <= WINDOW_RESET;
            r_ppm     <= PPM_RESET;
            r_clk_hz  <= CLK_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_AVERAGE_WINDOW:  r_avg_win <= i_cfg.data[WINDOW_W-1:0];
                CFG_PULSES_PER_MILE: r_ppm     <= i_cfg.data[PPM_W-1:0];
                CFG_TIMER_CLOCK_HZ:  r_clk_hz  <= i_cfg.data[CLK_W-1:0];
                default: ;
            endcase
        end
    end

    // capture: period to the previous stamp, noise floor
    assign period      = i_in.capture_ticks - r_prev_stamp;
    assign keep_period = cap_xfer && r_seen && (period >= MIN_PERIOD_TICKS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_stamp <= '0;
            r_seen       <= 1'b0;
            r_wslot      <= '0;
            r_fill       <= '0;
            r_last_pulse <= '0;
        end else if (cap_xfer) begin
            r_prev_stamp <= i_in.capture_ticks;
            r_seen       <= 1'b1;
            if (keep_period) begin
                r_wslot      <= (r_wslot == LAST_SLOT) ? '0 : r_wslot + 1'b1;
                r_last_pulse <= i_in.now_ms;
                if (r_fill != FULL_FILL) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
        end
    end

    // period ring
    ppsm_ram #(
        .WIDTH (STAMP_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (keep_period),
        .i_waddr (r_wslot),
        .i_wdata (period),
        .i_raddr (r_rslot),
        .o_rdata (ram_rdata)
    );

    // number of entries to average and the timeout test
    always_comb begin
        win_ext  = {{(8 - WINDOW_W){1'b0}}, r_avg_win};
        fill_ext = 8'(r_fill);
        n_min    = win_ext;
        if (n_min > 8'(RING_DEPTH)) begin
            n_min = 8'(RING_DEPTH);
        end
        if (n_min > fill_ext) begin
            n_min = fill_ext;
        end
        n_items   = n_min[CW-1:0];
        idle_ms   = i_in.now_ms - r_last_pulse;
        timed_out = idle_ms > PULSE_TIMEOUT_MS;
    end

    // shared multiplier, its product registered into the numerator or denominator register
    always_comb begin
        if (r_state == S_MUL_NUM) begin
            mul_a = {{(MUL_A_W - CLK_W){1'b0}}, r_clk_hz};
            mul_b = HOUR_Q8_SCALE;
        end else begin
            mul_a = r_avg;
            mul_b = r_ppm;
        end
        mul_p = mul_a * mul_b;
    end

    // sequencer for read items
    always_comb begin
        n_state       = r_state;
        n_rslot       = r_rslot;
        n_left        = r_left;
        n_n           = r_n;
        n_pend        = 1'b0;
        n_sum         = r_sum;
        n_avg         = r_avg;
        n_num         = r_num;
        n_den         = r_den;
        n_res_speed   = r_res_speed;
        n_res_stopped = r_res_stopped;
        div_req       = '0;
        div_dividend  = '0;
        div_divisor   = '0;
        n_out_valid   = r_out_valid && !o_out.ready;
        n_out_speed   = r_out_speed;
        n_out_stopped = r_out_stopped;

        case (r_state)
            S_IDLE: begin
                if (rd_xfer) begin
                    if (n_items == '0 || timed_out) begin
                        n_res_speed   = '0;
                        n_res_stopped = 1'b1;
                        n_state       = S_OUT;
                    end else if (r_ppm == '0) begin
                        n_res_speed   = '0;
                        n_res_stopped = 1'b0;
                        n_state       = S_OUT;
                    end else begin
                        n_rslot = (r_wslot == '0) ? LAST_SLOT : r_wslot - 1'b1;
                        n_left  = n_items;
                        n_n     = n_items;
                        n_sum   = '0;
                        n_state = S_SUM;
                    end
                end
            end
            S_SUM: begin
                // one ring read issued per cycle, its data added in the following cycle
                if (r_pend) begin
                    n_sum = r_sum + SW'(ram_rdata);
                end
                if (r_left != '0) begin
                    n_pend  = 1'b1;
                    n_left  = r_left - 1'b1;
                    n_rslot = (r_rslot == '0) ? LAST_SLOT : r_rslot - 1'b1;
                end else if (!r_pend) begin
                    div_req.start = 1'b1;
                    div_req.iters = DIV_CNT_W'(SW);
                    div_dividend  = DIV_W'(r_sum) << (DIV_W - SW);
                    div_divisor   = DIV_W'(r_n);
                    n_state       = S_AVG;
                end
            end
            S_AVG: begin
                if (div_done) begin
                    n_avg   = div_quo[STAMP_W-1:0];
                    n_state = S_MUL_NUM;
                end
            end
            S_MUL_NUM: begin
                n_num   = mul_p[NUM_W-1:0];
                n_state = S_MUL_DEN;
            end
            S_MUL_DEN: begin
                n_den   = mul_p;
                n_state = S_SPD;
            end
            S_SPD: begin
                // start once the product has landed, then wait for the quotient
                if (r_pend) begin
                    if (div_done) begin
                        if (div_quo > DIV_W'(SPEED_MAX)) begin
                            n_res_speed = SPEED_MAX;
                        end else begin
                            n_res_speed = div_quo[SPEED_W-1:0];
                        end
                        n_res_stopped = 1'b0;
                        n_state       = S_OUT;
                    end else begin
                        n_pend = 1'b1;
                    end
                end else begin
                    div_req.start = 1'b1;
                    div_req.iters = DIV_CNT_W'(NUM_W);
                    div_dividend  = DIV_W'(r_num) << (DIV_W - NUM_W);
                    div_divisor   = r_den;
                    n_pend        = 1'b1;
                end
            end
            S_OUT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid   = 1'b1;
                    n_out_speed   = r_res_speed;
                    n_out_stopped = r_res_stopped;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // shared divider for the average and the speed
    ppsm_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_left      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_left      <= n_left;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_rslot       <= n_rslot;
        r_n           <= n_n;
        r_sum         <= n_sum;
        r_avg         <= n_avg;
        r_num         <= n_num;
        r_den         <= n_den;
        r_res_speed   <= n_res_speed;
        r_res_stopped <= n_res_stopped;
        r_out_speed   <= n_out_speed;
        r_out_stopped <= n_out_stopped;
    end

    // channel outputs
    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.speed_mph_q8 = r_out_speed;
    assign o_out.stopped      = r_out_stopped;

endmodule

// ===== rtl/ppsm_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
module ppsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/ppsm_divider.sv =====
// restoring unsigned divider, one quotient bit per cycle
module ppsm_divider import ppsm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    input  logic [DIV_W-1:0] i_dividend,   // left aligned to the iteration count
    input  logic [DIV_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quotient
);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [DIV_W-1:0]     r_rem, n_rem;
    logic [DIV_W-1:0]     r_quo, n_quo;
    logic [DIV_W-1:0]     r_div, n_div;
    logic [DIV_W:0]       trial;
    logic [DIV_W:0]       diff;

    // one shift and trial subtract
    always_comb begin
        trial = {r_rem, r_quo[DIV_W-1]};
        diff  = trial - {1'b0, r_div};
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_div  = r_div;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = i_req.iters;
            n_rem  = '0;
            n_quo  = i_dividend;
            n_div  = i_divisor;
        end else if (r_busy) begin
            // a zero divisor yields all ones, which the caller saturates
            if (!diff[DIV_W]) begin
                n_rem = diff[DIV_W-1:0];
                n_quo = {r_quo[DIV_W-2:0], 1'b1};
            end else begin
                n_rem = trial[DIV_W-1:0];
                n_quo = {r_quo[DIV_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_div <= n_div;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
